[sv/ccml_pkg.sv]
package ccml_pkg;

    // Valid window of modified Julian days for a set request
    localparam logic [16:0] MJD_FIRST = 17'd57388;
    localparam logic [16:0] MJD_LAST  = 17'd88068;

    // Days in a four-year block and in a common year
    localparam logic [14:0] QUAD_DAYS = 15'd1461;
    localparam logic [14:0] YEAR_DAYS = 15'd365;

    // Year in century of the first day of the valid window
    localparam logic [6:0] BASE_YEAR = 7'd16;

    localparam logic [5:0] SEC_LAST  = 6'd59;
    localparam logic [5:0] MIN_LAST  = 6'd59;
    localparam logic [4:0] HOUR_LAST = 5'd23;
    localparam logic [3:0] MON_LAST  = 4'd12;
    localparam logic [6:0] YEAR_LAST = 7'd99;

    typedef enum logic [1:0] {
        CMD_TICK,
        CMD_SET,
        CMD_REJECT
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind   kind;
        logic [14:0] days;    // days since the first day of the window
        logic [4:0]  hour;
        logic [5:0]  minute;
    } t_cmd;

    // Days in a month; codes outside 1..12 read as 31
    function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        case (month)
            4'd2:    len = leap ? 5'd29 : 5'd28;
            4'd4:    len = 5'd30;
            4'd6:    len = 5'd30;
            4'd9:    len = 5'd30;
            4'd11:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

[sv/calendar_clock_with_mjd_load_top.sv]
// Calendar clock with modified-Julian-date load.
//
// Input channel (i_valid / o_ready): one request per transfer. i_req_type 0
// is a one-second tick; 1 sets the clock from i_mjd, i_set_hour and
// i_set_minute. Sets outside MJD 57388..88068, hour 0..23 or minute 0..59
// leave the clock alone and come back with o_set_rejected high.
// Output channel (o_valid / i_ready): exactly one result per request, in
// order, carrying the clock after that request.
//
// Flow: a tick or a rejected set is written into the command queue at its
// transfer and into the result register when the execution unit pops it.
// A valid set walks the date one step a cycle in the execution unit: up to
// 20 four-year blocks, up to 3 years and up to 11 months, each stage
// ending with an exit step. The execution unit finishes one request before
// it pops the next; ticks sustain one per cycle while the receiver takes
// each result.
//
// Reset (synchronous, active low) drops queued requests and any held result
// and sets the clock to 2016-01-01 00:00:00. When the receiver stalls, hold
// the result; the queue keeps taking requests until it is full, then o_ready
// drops.
module calendar_clock_with_mjd_load_top
    import ccml_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_req_type,
    input  logic [16:0] i_mjd,
    input  logic [4:0]  i_set_hour,
    input  logic [5:0]  i_set_minute,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [5:0]  o_cur_second,
    output logic [5:0]  o_cur_minute,
    output logic [4:0]  o_cur_hour,
    output logic [4:0]  o_cur_day,
    output logic [3:0]  o_cur_month,
    output logic [6:0]  o_cur_year,
    output logic        o_set_rejected
);

    t_cmd w_front_cmd;
    t_cmd w_q_cmd;
    logic w_q_full;
    logic w_q_nonempty;
    logic w_pop;

    // Classify each request before it enters the queue
    ccml_front u_front (
        .i_req_type   (i_req_type),
        .i_mjd        (i_mjd),
        .i_set_hour   (i_set_hour),
        .i_set_minute (i_set_minute),
        .o_cmd        (w_front_cmd)
    );

    assign o_ready = !w_q_full;

    ccml_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_valid),
        .i_cmd      (w_front_cmd),
        .o_full     (w_q_full),
        .i_pop      (w_pop),
        .o_nonempty (w_q_nonempty),
        .o_cmd      (w_q_cmd)
    );

    // Clock state, date conversion and the output register
    ccml_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_nonempty   (w_q_nonempty),
        .i_cmd          (w_q_cmd),
        .o_pop          (w_pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_cur_second   (o_cur_second),
        .o_cur_minute   (o_cur_minute),
        .o_cur_hour     (o_cur_hour),
        .o_cur_day      (o_cur_day),
        .o_cur_month    (o_cur_month),
        .o_cur_year     (o_cur_year),
        .o_set_rejected (o_set_rejected)
    );

endmodule

[sv/ccml_front.sv]
module ccml_front
    import ccml_pkg::*;
(
    input  logic        i_req_type,
    input  logic [16:0] i_mjd,
    input  logic [4:0]  i_set_hour,
    input  logic [5:0]  i_set_minute,
    output t_cmd        o_cmd
);

    logic        w_in_range;
    logic [14:0] w_offset;

    assign w_in_range = (i_mjd >= MJD_FIRST) && (i_mjd <= MJD_LAST)
                        && (i_set_hour <= HOUR_LAST) && (i_set_minute <= MIN_LAST);
    assign w_offset   = 15'(i_mjd - MJD_FIRST);

    // Classify: tick, valid set, or set to drop and flag
    always_comb begin
        o_cmd.days   = w_offset;
        o_cmd.hour   = i_set_hour;
        o_cmd.minute = i_set_minute;
        if (!i_req_type) begin
            o_cmd.kind = CMD_TICK;
        end else if (w_in_range) begin
            o_cmd.kind = CMD_SET;
        end else begin
            o_cmd.kind = CMD_REJECT;
        end
    end

endmodule

[sv/ccml_queue.sv]
module ccml_queue
    import ccml_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_nonempty,
    output t_cmd o_cmd
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd               r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    logic w_push;
    logic w_pop;

    assign o_full     = (r_count == CNT_W'(DEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_cmd      = r_mem[r_rd_ptr];
    assign w_push     = i_push && !o_full;
    assign w_pop      = i_pop && o_nonempty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[sv/ccml_back.sv]
module ccml_back
    import ccml_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_nonempty,
    input  t_cmd       i_cmd,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [5:0] o_cur_second,
    output logic [5:0] o_cur_minute,
    output logic [4:0] o_cur_hour,
    output logic [4:0] o_cur_day,
    output logic [3:0] o_cur_month,
    output logic [6:0] o_cur_year,
    output logic       o_set_rejected
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_QUAD,
        S_YEAR,
        S_MONTH
    } t_state;

    t_state      r_state;
    logic [5:0]  r_sec;
    logic [5:0]  r_min;
    logic [4:0]  r_hour;
    logic [4:0]  r_day;
    logic [3:0]  r_mon;
    logic [6:0]  r_year;
    // Conversion work registers
    logic [14:0] r_days;
    logic [6:0]  r_cv_year;
    logic [3:0]  r_cv_mon;
    logic [4:0]  r_cv_hour;
    logic [5:0]  r_cv_min;
    logic        r_out_valid;

    logic        w_out_free;
    logic        w_out_load;
    // One-second advance
    logic [5:0]  n_sec;
    logic [5:0]  n_min;
    logic [4:0]  n_hour;
    logic [4:0]  n_day;
    logic [3:0]  n_mon;
    logic [6:0]  n_year;
    logic [4:0]  w_last_day;
    // Conversion step
    logic        w_cv_leap;
    logic [14:0] w_year_len;
    logic [14:0] w_mon_len;

    assign w_out_free = !r_out_valid || i_ready;
    assign o_pop      = (r_state == S_IDLE) && i_q_nonempty && w_out_free;
    assign o_valid    = r_out_valid;
    // Load the output register on a tick, a dropped set or a finished conversion
    assign w_out_load = (o_pop && (i_cmd.kind != CMD_SET))
                        || ((r_state == S_MONTH) && (r_days < w_mon_len));

    always_comb begin
        w_last_day = month_len(r_mon, r_year[1:0] == 2'd0);
        n_sec  = r_sec + 1'b1;
        n_min  = r_min;
        n_hour = r_hour;
        n_day  = r_day;
        n_mon  = r_mon;
        n_year = r_year;
        if (r_sec >= SEC_LAST) begin
            n_sec = '0;
            n_min = r_min + 1'b1;
            if (r_min >= MIN_LAST) begin
                n_min  = '0;
                n_hour = r_hour + 1'b1;
                if (r_hour >= HOUR_LAST) begin
                    n_hour = '0;
                    n_day  = r_day + 1'b1;
                    if (r_day >= w_last_day) begin
                        n_day = 5'd1;
                        n_mon = r_mon + 1'b1;
                        if (r_mon >= MON_LAST) begin
                            n_mon  = 4'd1;
                            n_year = (r_year >= YEAR_LAST) ? '0 : r_year + 1'b1;
                        end
                    end
                end
            end
        end
    end

    assign w_cv_leap  = (r_cv_year[1:0] == 2'd0);
    assign w_year_len = YEAR_DAYS + {14'd0, w_cv_leap};
    assign w_mon_len  = {10'd0, month_len(r_cv_mon, w_cv_leap)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sec       <= '0;
            r_min       <= '0;
            r_hour      <= '0;
            r_day       <= 5'd1;
            r_mon       <= 4'd1;
            r_year      <= BASE_YEAR;
            r_out_valid <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        case (i_cmd.kind)
                            CMD_TICK: begin
                                r_sec <= n_sec;  r_min <= n_min;  r_hour <= n_hour;
                                r_day <= n_day;  r_mon <= n_mon;  r_year <= n_year;
                                o_cur_second   <= n_sec;
                                o_cur_minute   <= n_min;
                                o_cur_hour     <= n_hour;
                                o_cur_day      <= n_day;
                                o_cur_month    <= n_mon;
                                o_cur_year     <= n_year;
                                o_set_rejected <= 1'b0;
                            end
                            CMD_SET: begin
                                r_days    <= i_cmd.days;
                                r_cv_year <= BASE_YEAR;
                                r_cv_mon  <= 4'd1;
                                r_cv_hour <= i_cmd.hour;
                                r_cv_min  <= i_cmd.minute;
                                r_state   <= S_QUAD;
                            end
                            default: begin
                                // Drop the set, report the clock unchanged
                                o_cur_second   <= r_sec;
                                o_cur_minute   <= r_min;
                                o_cur_hour     <= r_hour;
                                o_cur_day      <= r_day;
                                o_cur_month    <= r_mon;
                                o_cur_year     <= r_year;
                                o_set_rejected <= 1'b1;
                            end
                        endcase
                    end
                end
                S_QUAD: begin
                    if (r_days >= QUAD_DAYS) begin
                        r_days    <= r_days - QUAD_DAYS;
                        r_cv_year <= r_cv_year + 7'd4;
                    end else begin
                        r_state <= S_YEAR;
                    end
                end
                S_YEAR: begin
                    if (r_days >= w_year_len) begin
                        r_days    <= r_days - w_year_len;
                        r_cv_year <= r_cv_year + 1'b1;
                    end else begin
                        r_state <= S_MONTH;
                    end
                end
                S_MONTH: begin
                    if (r_days >= w_mon_len) begin
                        r_days   <= r_days - w_mon_len;
                        r_cv_mon <= r_cv_mon + 1'b1;
                    end else begin
                        // Commit; output register was freed when the set was popped
                        r_sec  <= '0;
                        r_min  <= r_cv_min;
                        r_hour <= r_cv_hour;
                        r_day  <= r_days[4:0] + 1'b1;
                        r_mon  <= r_cv_mon;
                        r_year <= r_cv_year;
                        o_cur_second   <= '0;
                        o_cur_minute   <= r_cv_min;
                        o_cur_hour     <= r_cv_hour;
                        o_cur_day      <= r_days[4:0] + 1'b1;
                        o_cur_month    <= r_cv_mon;
                        o_cur_year     <= r_cv_year;
                        o_set_rejected <= 1'b0;
                        r_state        <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[sv/ccml_checker.sv]
module ccml_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic [5:0] o_cur_second,
    input logic [5:0] o_cur_minute,
    input logic [4:0] o_cur_hour,
    input logic [4:0] o_cur_day,
    input logic [3:0] o_cur_month,
    input logic [6:0] o_cur_year
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("result dropped while stalled");

    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_cur_second <= 6'd59) && (o_cur_minute <= 6'd59)
                    && (o_cur_hour <= 5'd23))
        else $error("time of day out of range");

    a_date_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_cur_day != 5'd0) && (o_cur_month != 4'd0)
                    && (o_cur_month <= 4'd12) && (o_cur_year <= 7'd99))
        else $error("date out of range");

endmodule

bind calendar_clock_with_mjd_load_top ccml_checker u_ccml_checker (.*);
